/* src/jaei_pkg.sv */
package jaei_pkg;

   // Parser phases, one per stage of the document grammar.
   typedef enum logic [3:0] {
      PH_ROOT,
      PH_KEY_FRESH,
      PH_KEY_WS,
      PH_KEY,
      PH_COLON,
      PH_VALUE,
      PH_SKIP,
      PH_ARRAY,
      PH_DONE,
      PH_ERROR
   } phase_type;

   // Kinds of result.
   typedef enum logic [1:0] {
      KIND_SPAN,
      KIND_ARRAY_END,
      KIND_ERROR
   } kind_type;

   // Error codes.
   typedef enum logic [2:0] {
      ERR_NO_ROOT,
      ERR_KEY_EXPECTED,
      ERR_KEY_UNTERMINATED,
      ERR_COLON_EXPECTED,
      ERR_ARRAY_EXPECTED,
      ERR_ARRAY_UNTERMINATED,
      ERR_KEY_MISSING
   } err_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_KEY_LOW,
      CSR_KEY_HIGH,
      CSR_KEY_LENGTH
   } csr_index_type;

   // One result as it travels from the parser to the output stage.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] number;
      logic [31:0] offset;
      logic [31:0] length;
      logic        last_flag;
      err_type     error_code;
   } result_type;

   // Characters of interest.
   localparam logic [7:0] CH_LBRACK    = 8'h5B;
   localparam logic [7:0] CH_RBRACK    = 8'h5D;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;

   // JSON whitespace.
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

endpackage

/* src/json_keyed_array_element_indexer.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  doc_byte, end_of_document
// rsp       out        rsp_valid/rsp_stall  kind, number, offset, length, final, error
// csr       in         csr_write            csr_index, csr_data
//
// One document byte is taken every cycle while req_stall is low; the parser state is
// updated by compare and counter logic, and a result is registered in the output stage.
// Synchronous reset clears the parser and the key registers. Results wait in the output
// register and a skid entry; req_stall rises only when both hold a result, and the
// configuration is kept across documents.
module json_keyed_array_element_indexer #(
   parameter int KEY_MAX_BYTES = 16,
   parameter int DEPTH_MAX     = 255,
   parameter int OFFSET_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_doc_byte,
   input  logic        req_end_of_document,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_element_number,
   output logic [31:0] rsp_element_offset,
   output logic [31:0] rsp_element_length,
   output logic        rsp_final_element,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import jaei_pkg::*;

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [4:0]  key_length_ff;
   logic        req_accept;
   logic        res_valid;
   result_type  res;
   result_type  out_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_LOW:    key_low_ff    <= csr_data;
            CSR_KEY_HIGH:   key_high_ff   <= csr_data;
            CSR_KEY_LENGTH: key_length_ff <= csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   assign req_accept = req_valid && !req_stall;

   jaei_parser #(
      .KEY_MAX_BYTES (KEY_MAX_BYTES),
      .DEPTH_MAX     (DEPTH_MAX),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (req_accept),
      .doc_byte        (req_doc_byte),
      .end_of_document (req_end_of_document),
      .key_low         (key_low_ff),
      .key_high        (key_high_ff),
      .key_length      (key_length_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   jaei_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && res_valid),
      .push_data (res),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   // Result fields onto their ports.
   assign rsp_result_kind    = out_data.kind;
   assign rsp_element_number = out_data.number;
   assign rsp_element_offset = out_data.offset;
   assign rsp_element_length = out_data.length;
   assign rsp_final_element  = out_data.last_flag;
   assign rsp_error_code     = out_data.error_code;

`ifndef SYNTHESIS
   // A full skid entry always sits behind a waiting result.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // The input is only held off after the output has been stalled.
   assert property (@(posedge clock) disable iff (reset) $rose(req_stall) |-> $past(rsp_stall))
      else $error("input stall rose without an output stall");

   // Only spans carry offset, length and the final flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != KIND_SPAN) |->
         (rsp_element_offset == 32'd0 && rsp_element_length == 32'd0 && !rsp_final_element))
      else $error("non-span result carries span fields");

   // Only errors carry an error code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != KIND_ERROR) |-> (rsp_error_code == 3'd0))
      else $error("non-error result carries an error code");
`endif

endmodule

/* src/jaei_parser.sv */
module jaei_parser #(
   parameter int KEY_MAX_BYTES = 16,
   parameter int DEPTH_MAX     = 255,
   parameter int OFFSET_BITS   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           doc_byte,
   input  logic                 end_of_document,
   input  logic [63:0]          key_low,
   input  logic [63:0]          key_high,
   input  logic [4:0]           key_length,
   output logic                 res_valid,
   output jaei_pkg::result_type res
);
   import jaei_pkg::*;

   localparam int DW  = $clog2(DEPTH_MAX + 1);
   localparam int KCW = $clog2(KEY_MAX_BYTES + 2);
   localparam int OB  = OFFSET_BITS;
   localparam logic [DW-1:0]  DEPTH_TOP = DW'(DEPTH_MAX);
   localparam logic [KCW-1:0] KCNT_TOP  = KCW'(KEY_MAX_BYTES + 1);
   localparam logic [4:0]     KEY_LIMIT = 5'(KEY_MAX_BYTES);

   phase_type      phase_ff, phase_in;
   logic [OB-1:0]  pos_ff, pos_in;
   logic           in_str_ff, in_str_in;
   logic           esc_ff, esc_in;
   logic [KCW-1:0] kcnt_ff, kcnt_in;
   logic           kmatch_ff, kmatch_in;
   logic [DW-1:0]  bdepth_ff, bdepth_in;
   logic [DW-1:0]  edepth_ff, edepth_in;
   logic           eopen_ff, eopen_in;
   logic [31:0]    ecount_ff, ecount_in;
   logic [OB-1:0]  estart_ff, estart_in;
   logic [OB-1:0]  lend_ff, lend_in;

   logic [127:0]   key_all;
   logic [4:0]     kidx;
   logic [7:0]     want;
   logic           key_hit;
   logic [KCW-1:0] kcnt_step;
   logic [OB-1:0]  pos_next;
   logic [OB-1:0]  span_len;

   function automatic logic [DW-1:0] depth_up(input logic [DW-1:0] d);
      return (d < DEPTH_TOP) ? DW'(d + 1'b1) : d;
   endfunction

   function automatic logic [DW-1:0] depth_down(input logic [DW-1:0] d);
      return (d != '0) ? DW'(d - 1'b1) : d;
   endfunction

   // Key byte comparison against the configured key.
   assign key_all   = {key_high, key_low};
   assign kidx      = 5'(kcnt_ff);
   assign want      = key_all[{kidx[3:0], 3'b000} +: 8];
   assign key_hit   = (kidx < key_length) && (kidx < KEY_LIMIT) && (want == doc_byte);
   assign kcnt_step = (kcnt_ff < KCNT_TOP) ? KCW'(kcnt_ff + 1'b1) : kcnt_ff;
   assign pos_next  = OB'(pos_ff + 1'b1);
   assign span_len  = OB'(lend_ff - estart_ff);

   // Parser state registers, updated once per transferred byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ROOT;
         pos_ff    <= '0;
         in_str_ff <= 1'b0;
         esc_ff    <= 1'b0;
         kcnt_ff   <= '0;
         kmatch_ff <= 1'b1;
         bdepth_ff <= '0;
         edepth_ff <= '0;
         eopen_ff  <= 1'b0;
         ecount_ff <= '0;
         estart_ff <= '0;
         lend_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         in_str_ff <= in_str_in;
         esc_ff    <= esc_in;
         kcnt_ff   <= kcnt_in;
         kmatch_ff <= kmatch_in;
         bdepth_ff <= bdepth_in;
         edepth_ff <= edepth_in;
         eopen_ff  <= eopen_in;
         ecount_ff <= ecount_in;
         estart_ff <= estart_in;
         lend_ff   <= lend_in;
      end
   end

   // Next state and result for the byte on the input.
   always_comb begin
      logic          space;
      logic          raised;
      logic [DW-1:0] ed_eff;
      logic          skip_rest;

      space     = is_space(doc_byte);
      raised    = 1'b0;
      ed_eff    = edepth_ff;
      skip_rest = 1'b0;

      phase_in  = phase_ff;
      pos_in    = pos_next;
      in_str_in = in_str_ff;
      esc_in    = esc_ff;
      kcnt_in   = kcnt_ff;
      kmatch_in = kmatch_ff;
      bdepth_in = bdepth_ff;
      edepth_in = edepth_ff;
      eopen_in  = eopen_ff;
      ecount_in = ecount_ff;
      estart_in = estart_ff;
      lend_in   = lend_ff;
      res_valid = 1'b0;
      res       = '0;

      unique case (phase_ff)
         PH_ROOT: begin
            if (doc_byte == CH_LBRACE) begin
               phase_in = PH_KEY_FRESH;
            end else if (!space) begin
               raised         = 1'b1;
               res.error_code = ERR_NO_ROOT;
            end
         end
         PH_KEY_FRESH, PH_KEY_WS: begin
            if (space) begin
               phase_in = PH_KEY_WS;
            end else if (doc_byte == CH_QUOTE) begin
               phase_in  = PH_KEY;
               kcnt_in   = '0;
               kmatch_in = 1'b1;
               esc_in    = 1'b0;
            end else begin
               raised = 1'b1;
               if (doc_byte == CH_RBRACE) begin
                  res.error_code = ERR_KEY_MISSING;
               end else begin
                  res.error_code = ERR_KEY_EXPECTED;
               end
            end
         end
         PH_KEY: begin
            if (!esc_ff && doc_byte == CH_QUOTE) begin
               kmatch_in = kmatch_ff && (5'(kcnt_ff) == key_length);
               phase_in  = PH_COLON;
            end else begin
               // Escapes are compared raw; a backslash arms the escape.
               esc_in    = !esc_ff && (doc_byte == CH_BACKSLASH);
               kmatch_in = kmatch_ff && key_hit;
               kcnt_in   = kcnt_step;
            end
         end
         PH_COLON: begin
            if (doc_byte == CH_COLON) begin
               in_str_in = 1'b0;
               esc_in    = 1'b0;
               edepth_in = '0;
               phase_in  = kmatch_ff ? PH_VALUE : PH_SKIP;
            end else if (!space) begin
               raised         = 1'b1;
               res.error_code = ERR_COLON_EXPECTED;
            end
         end
         PH_VALUE: begin
            if (doc_byte == CH_LBRACK) begin
               phase_in  = PH_ARRAY;
               bdepth_in = DW'(1);
               edepth_in = '0;
               eopen_in  = 1'b0;
               ecount_in = '0;
               in_str_in = 1'b0;
               esc_in    = 1'b0;
            end else if (!space) begin
               raised         = 1'b1;
               res.error_code = ERR_ARRAY_EXPECTED;
            end
         end
         PH_SKIP: begin
            if (in_str_ff) begin
               if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (doc_byte == CH_BACKSLASH) begin
                  esc_in = 1'b1;
               end else if (doc_byte == CH_QUOTE) begin
                  in_str_in = 1'b0;
               end
            end else if (doc_byte == CH_QUOTE) begin
               in_str_in = 1'b1;
            end else if (doc_byte == CH_LBRACE || doc_byte == CH_LBRACK) begin
               edepth_in = depth_up(edepth_ff);
            end else if (doc_byte == CH_RBRACE || doc_byte == CH_RBRACK) begin
               if (edepth_ff == '0) begin
                  raised = 1'b1;
                  if (doc_byte == CH_RBRACE) begin
                     res.error_code = ERR_KEY_MISSING;
                  end else begin
                     res.error_code = ERR_KEY_EXPECTED;
                  end
               end else begin
                  edepth_in = DW'(edepth_ff - 1'b1);
               end
            end else if (doc_byte == CH_COMMA && edepth_ff == '0) begin
               phase_in = PH_KEY_FRESH;
            end
         end
         PH_ARRAY: begin
            if (in_str_ff) begin
               if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (doc_byte == CH_BACKSLASH) begin
                  esc_in = 1'b1;
               end else if (doc_byte == CH_QUOTE) begin
                  in_str_in = 1'b0;
               end
               if (!space) begin
                  lend_in = pos_next;
               end
            end else if (doc_byte == CH_RBRACK && bdepth_ff <= DW'(1)) begin
               // Closing bracket of the array itself.
               bdepth_in = '0;
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               if (eopen_ff) begin
                  res.kind      = KIND_SPAN;
                  res.number    = ecount_ff;
                  res.offset    = 32'(estart_ff);
                  res.length    = 32'(span_len);
                  res.last_flag = 1'b1;
                  ecount_in     = 32'(ecount_ff + 1'b1);
                  eopen_in      = 1'b0;
               end else begin
                  res.kind   = KIND_ARRAY_END;
                  res.number = ecount_ff;
               end
            end else begin
               // Open a new element on its first significant byte.
               if (!eopen_ff) begin
                  if (space || doc_byte == CH_COMMA) begin
                     skip_rest = 1'b1;
                  end else begin
                     eopen_in  = 1'b1;
                     estart_in = pos_ff;
                     ed_eff    = '0;
                     edepth_in = '0;
                  end
               end
               if (!skip_rest) begin
                  if (doc_byte == CH_COMMA && ed_eff == '0) begin
                     res_valid     = 1'b1;
                     res.kind      = KIND_SPAN;
                     res.number    = ecount_ff;
                     res.offset    = 32'(estart_ff);
                     res.length    = 32'(span_len);
                     res.last_flag = 1'b0;
                     ecount_in     = 32'(ecount_ff + 1'b1);
                     eopen_in      = 1'b0;
                  end else begin
                     if (doc_byte == CH_QUOTE) begin
                        in_str_in = 1'b1;
                     end else if (doc_byte == CH_LBRACE) begin
                        edepth_in = depth_up(ed_eff);
                     end else if (doc_byte == CH_LBRACK) begin
                        edepth_in = depth_up(ed_eff);
                        bdepth_in = depth_up(bdepth_ff);
                     end else if (doc_byte == CH_RBRACE) begin
                        edepth_in = depth_down(ed_eff);
                     end else if (doc_byte == CH_RBRACK) begin
                        edepth_in = depth_down(ed_eff);
                        bdepth_in = depth_down(bdepth_ff);
                     end
                     if (!space) begin
                        lend_in = pos_next;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // A parse error ends the document.
      if (raised) begin
         phase_in  = PH_ERROR;
         res_valid = 1'b1;
         res.kind  = KIND_ERROR;
      end

      // End of document: report an unfinished parse, then start afresh.
      if (end_of_document) begin
         if (!raised && phase_in != PH_DONE && phase_in != PH_ERROR) begin
            res_valid = 1'b1;
            res       = '0;
            res.kind  = KIND_ERROR;
            if (phase_ff == PH_KEY || phase_in == PH_KEY) begin
               res.error_code = ERR_KEY_UNTERMINATED;
            end else if (phase_in == PH_ROOT) begin
               res.error_code = ERR_NO_ROOT;
            end else if (phase_in == PH_KEY_WS) begin
               res.error_code = ERR_KEY_EXPECTED;
            end else if (phase_in == PH_COLON) begin
               res.error_code = ERR_COLON_EXPECTED;
            end else if (phase_in == PH_VALUE) begin
               res.error_code = ERR_ARRAY_EXPECTED;
            end else if (phase_in == PH_ARRAY) begin
               res.error_code = ERR_ARRAY_UNTERMINATED;
            end else begin
               res.error_code = ERR_KEY_MISSING;
            end
         end
         phase_in  = PH_ROOT;
         pos_in    = '0;
         in_str_in = 1'b0;
         esc_in    = 1'b0;
         kcnt_in   = '0;
         kmatch_in = 1'b1;
         bdepth_in = '0;
         edepth_in = '0;
         eopen_in  = 1'b0;
         ecount_in = '0;
         estart_in = '0;
         lend_in   = '0;
      end
   end

endmodule

/* src/jaei_outbuf.sv */
module jaei_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jaei_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output jaei_pkg::result_type out_data
);
   import jaei_pkg::*;

   logic       main_valid_ff, main_valid_in;
   result_type main_data_ff, main_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       main_free;

   // The main stage can take data when empty or when its result transfers now.
   assign main_free = !main_valid_ff || !out_stall;

   // Output stage with a skid entry behind it.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

/* test/json_keyed_array_element_indexer_tb.sv */
module json_keyed_array_element_indexer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jaei_pkg::*;

   localparam int ITEM_GOAL   = 550;
   localparam int HOLD_CYCLES = 300;
   localparam int DEEP_LEVELS = 256;
   localparam int DRAIN_WAIT  = 4;

   // One row of the opening stimulus, with the result typed in where it is obvious.
   typedef struct packed {
      logic [7:0] ch;
      logic       eod;
      logic       typed;
      result_type want;
   } step_row_type;

   localparam result_type NO_RESULT = '{KIND_SPAN, 32'd0, 32'd0, 32'd0, 1'b0, ERR_NO_ROOT};

   localparam step_row_type OPENING_STEPS [28] = '{
      // Bad root bytes at both extremes, then a byte ignored up to the document end.
      '{8'h00, 1'b1, 1'b1, '{KIND_ERROR, 32'd0, 32'd0, 32'd0, 1'b0, ERR_NO_ROOT}},
      '{8'hFF, 1'b0, 1'b1, '{KIND_ERROR, 32'd0, 32'd0, 32'd0, 1'b0, ERR_NO_ROOT}},
      '{CH_LBRACE, 1'b1, 1'b0, NO_RESULT},
      // The empty key matches the reset key length; its array holds two spans and a
      // trailing comma.
      '{CH_LBRACE, 1'b0, 1'b0, NO_RESULT},
      '{CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
      '{CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
      '{CH_COLON, 1'b0, 1'b0, NO_RESULT},
      '{CH_TAB, 1'b0, 1'b0, NO_RESULT},
      '{CH_LBRACK, 1'b0, 1'b0, NO_RESULT},
      '{8'h37, 1'b0, 1'b0, NO_RESULT},
      '{CH_SPACE, 1'b0, 1'b0, NO_RESULT},
      '{CH_COMMA, 1'b0, 1'b1, '{KIND_SPAN, 32'd0, 32'd6, 32'd1, 1'b0, ERR_NO_ROOT}},
      '{CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
      '{CH_RBRACK, 1'b0, 1'b0, NO_RESULT},
      '{CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
      '{CH_LF, 1'b0, 1'b0, NO_RESULT},
      '{CH_COMMA, 1'b0, 1'b1, '{KIND_SPAN, 32'd1, 32'd9, 32'd3, 1'b0, ERR_NO_ROOT}},
      '{CH_CR, 1'b0, 1'b0, NO_RESULT},
      '{CH_RBRACK, 1'b0, 1'b1, '{KIND_ARRAY_END, 32'd2, 32'd0, 32'd0, 1'b0, ERR_NO_ROOT}},
      '{CH_RBRACE, 1'b1, 1'b0, NO_RESULT},
      // A closing brace where a key should be.
      '{CH_LBRACE, 1'b0, 1'b0, NO_RESULT},
      '{CH_RBRACE, 1'b0, 1'b1, '{KIND_ERROR, 32'd0, 32'd0, 32'd0, 1'b0, ERR_KEY_MISSING}},
      '{8'h41, 1'b1, 1'b0, NO_RESULT},
      // Document ends after whitespace where a key is expected.
      '{CH_LBRACE, 1'b0, 1'b0, NO_RESULT},
      '{CH_SPACE, 1'b1, 1'b1, '{KIND_ERROR, 32'd0, 32'd0, 32'd0, 1'b0, ERR_KEY_EXPECTED}},
      // Document ends inside a key.
      '{CH_LBRACE, 1'b0, 1'b0, NO_RESULT},
      '{CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
      '{8'h61, 1'b1, 1'b1, '{KIND_ERROR, 32'd0, 32'd0, 32'd0, 1'b0, ERR_KEY_UNTERMINATED}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_doc_byte = 8'd0;
   logic        req_end_of_document = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [31:0] rsp_element_number;
   logic [31:0] rsp_element_offset;
   logic [31:0] rsp_element_length;
   logic        rsp_final_element;
   logic [2:0]  rsp_error_code;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [63:0] csr_data = 64'd0;

   json_keyed_array_element_indexer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_doc_byte        (req_doc_byte),
      .req_end_of_document (req_end_of_document),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_element_number  (rsp_element_number),
      .rsp_element_offset  (rsp_element_offset),
      .rsp_element_length  (rsp_element_length),
      .rsp_final_element   (rsp_final_element),
      .rsp_error_code      (rsp_error_code),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #2 clock = ~clock;

   // Results still owed by the block, oldest first.
   result_type awaited_results [$];

   int  fail_count = 0;
   int  bytes_sent = 0;
   int  docs_sent = 0;
   int  key_settings = 0;
   int  results_due = 0;
   int  results_seen = 0;
   int  spans_seen = 0;
   bit  steady = 1'b0;
   bit  hold_wanted = 1'b0;
   bit  hold_served = 1'b0;
   int  hold_left = 0;

   // Predictor copy of the key registers.
   logic [63:0] key_lo;
   logic [63:0] key_hi;
   logic [4:0]  key_len;

   // Predictor copy of the parser state.
   phase_type   phase;
   logic [31:0] byte_pos;
   logic        in_str;
   logic        esc;
   logic [4:0]  kcount;
   logic        kmatch;
   logic [7:0]  bdepth;
   logic [7:0]  edepth;
   logic        el_open;
   logic [31:0] el_count;
   logic [31:0] el_start;
   logic [31:0] el_end;

   // Document under construction and the key that the generator aims at.
   logic [7:0]  doc_text [$];
   logic [7:0]  key_text [16];
   int          key_span;

   // Appends one byte to the document under construction.
   function automatic void add_byte(input logic [7:0] c);
      doc_text.insert(doc_text.size(), c);
   endfunction

   function automatic logic blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic logic [7:0] deeper(input logic [7:0] d);
      return (d < 8'd255) ? d + 8'd1 : d;
   endfunction

   function automatic logic [7:0] shallower(input logic [7:0] d);
      return (d > 8'd0) ? d - 8'd1 : 8'd0;
   endfunction

   function automatic void clear_doc();
      phase    = PH_ROOT;
      byte_pos = '0;
      in_str   = 1'b0;
      esc      = 1'b0;
      kcount   = '0;
      kmatch   = 1'b1;
      bdepth   = '0;
      edepth   = '0;
      el_open  = 1'b0;
      el_count = '0;
      el_start = '0;
      el_end   = '0;
   endfunction

   function automatic result_type fault(input err_type code);
      phase = PH_ERROR;
      return '{KIND_ERROR, 32'd0, 32'd0, 32'd0, 1'b0, code};
   endfunction

   // Raw key bytes are compared one by one; positions past the key never match.
   function automatic void compare_key(input logic [7:0] c);
      logic [63:0] word;
      logic [7:0]  wanted;
      if (kcount < key_len && kcount < 5'd16) begin
         word = (kcount < 5'd8) ? key_lo : key_hi;
         wanted = 8'(word >> {kcount[2:0], 3'b000});
         if (wanted != c) kmatch = 1'b0;
      end else begin
         kmatch = 1'b0;
      end
      if (kcount < 5'd17) kcount = kcount + 5'd1;
   endfunction

   function automatic result_type take_span(input logic fin);
      result_type r;
      r = '{KIND_SPAN, el_count, el_start, el_end - el_start, fin, ERR_NO_ROOT};
      el_count = el_count + 32'd1;
      el_open = 1'b0;
      return r;
   endfunction

   // One byte inside the wanted array.
   function automatic logic array_byte(input logic [7:0] c, input logic [31:0] here,
                                       output result_type res);
      res = NO_RESULT;
      if (in_str) begin
         if (esc) esc = 1'b0;
         else if (c == CH_BACKSLASH) esc = 1'b1;
         else if (c == CH_QUOTE) in_str = 1'b0;
         if (!blank(c)) el_end = here + 32'd1;
         return 1'b0;
      end
      if (c == CH_RBRACK && bdepth <= 8'd1) begin
         bdepth = '0;
         phase = PH_DONE;
         if (el_open) begin
            res = take_span(1'b1);
         end else begin
            res = '{KIND_ARRAY_END, el_count, 32'd0, 32'd0, 1'b0, ERR_NO_ROOT};
         end
         return 1'b1;
      end
      if (!el_open) begin
         if (blank(c) || c == CH_COMMA) return 1'b0;
         el_open = 1'b1;
         el_start = here;
         edepth = '0;
      end
      if (c == CH_COMMA && edepth == 8'd0) begin
         res = take_span(1'b0);
         return 1'b1;
      end
      case (c)
         CH_QUOTE:  in_str = 1'b1;
         CH_LBRACE: edepth = deeper(edepth);
         CH_LBRACK: begin
            edepth = deeper(edepth);
            bdepth = deeper(bdepth);
         end
         CH_RBRACE: edepth = shallower(edepth);
         CH_RBRACK: begin
            edepth = shallower(edepth);
            bdepth = shallower(bdepth);
         end
         default: ;
      endcase
      if (!blank(c)) el_end = here + 32'd1;
      return 1'b0;
   endfunction

   // Works out the result, if any, that one accepted document byte causes.
   function automatic logic index_byte(input logic [7:0] c, input logic eod,
                                       output result_type res);
      phase_type   entry_phase;
      logic [31:0] here;
      logic        made;
      logic        raised;
      err_type     code;
      entry_phase = phase;
      here = byte_pos;
      made = 1'b0;
      raised = 1'b0;
      res = NO_RESULT;
      case (phase)
         PH_ROOT: begin
            if (c == CH_LBRACE) begin
               phase = PH_KEY_FRESH;
            end else if (!blank(c)) begin
               res = fault(ERR_NO_ROOT);
               made = 1'b1;
               raised = 1'b1;
            end
         end
         PH_KEY_FRESH, PH_KEY_WS: begin
            if (blank(c)) begin
               phase = PH_KEY_WS;
            end else if (c == CH_QUOTE) begin
               phase = PH_KEY;
               kcount = '0;
               kmatch = 1'b1;
               esc = 1'b0;
            end else begin
               res = fault(c == CH_RBRACE ? ERR_KEY_MISSING : ERR_KEY_EXPECTED);
               made = 1'b1;
               raised = 1'b1;
            end
         end
         PH_KEY: begin
            if (esc) begin
               esc = 1'b0;
               compare_key(c);
            end else if (c == CH_BACKSLASH) begin
               esc = 1'b1;
               compare_key(c);
            end else if (c == CH_QUOTE) begin
               kmatch = kmatch && (kcount == key_len);
               phase = PH_COLON;
            end else begin
               compare_key(c);
            end
         end
         PH_COLON: begin
            if (c == CH_COLON) begin
               in_str = 1'b0;
               esc = 1'b0;
               edepth = '0;
               phase = kmatch ? PH_VALUE : PH_SKIP;
            end else if (!blank(c)) begin
               res = fault(ERR_COLON_EXPECTED);
               made = 1'b1;
               raised = 1'b1;
            end
         end
         PH_VALUE: begin
            if (c == CH_LBRACK) begin
               phase = PH_ARRAY;
               bdepth = 8'd1;
               edepth = '0;
               el_open = 1'b0;
               el_count = '0;
               in_str = 1'b0;
               esc = 1'b0;
            end else if (!blank(c)) begin
               res = fault(ERR_ARRAY_EXPECTED);
               made = 1'b1;
               raised = 1'b1;
            end
         end
         PH_SKIP: begin
            if (in_str) begin
               if (esc) esc = 1'b0;
               else if (c == CH_BACKSLASH) esc = 1'b1;
               else if (c == CH_QUOTE) in_str = 1'b0;
            end else if (c == CH_QUOTE) begin
               in_str = 1'b1;
            end else if (c == CH_LBRACE || c == CH_LBRACK) begin
               edepth = deeper(edepth);
            end else if (c == CH_RBRACE || c == CH_RBRACK) begin
               if (edepth == 8'd0) begin
                  res = fault(c == CH_RBRACE ? ERR_KEY_MISSING : ERR_KEY_EXPECTED);
                  made = 1'b1;
                  raised = 1'b1;
               end else begin
                  edepth = edepth - 8'd1;
               end
            end else if (c == CH_COMMA && edepth == 8'd0) begin
               phase = PH_KEY_FRESH;
            end
         end
         PH_ARRAY: made = array_byte(c, here, res);
         default: ;
      endcase
      byte_pos = here + 32'd1;

      // An early end reports the error of the phase reached, replacing any span.
      if (eod) begin
         if (!raised && phase != PH_DONE && phase != PH_ERROR) begin
            if (entry_phase == PH_KEY) begin
               code = ERR_KEY_UNTERMINATED;
            end else begin
               case (phase)
                  PH_ROOT:   code = ERR_NO_ROOT;
                  PH_KEY_WS: code = ERR_KEY_EXPECTED;
                  PH_KEY:    code = ERR_KEY_UNTERMINATED;
                  PH_COLON:  code = ERR_COLON_EXPECTED;
                  PH_VALUE:  code = ERR_ARRAY_EXPECTED;
                  PH_ARRAY:  code = ERR_ARRAY_UNTERMINATED;
                  default:   code = ERR_KEY_MISSING;
               endcase
            end
            res = fault(code);
            made = 1'b1;
         end
         clear_doc();
      end
      return made;
   endfunction

   // Offers one byte, waits for its transfer and records what it should cause.
   task automatic push_byte(input logic [7:0] c, input logic eod, input logic typed,
                            input result_type typed_res);
      result_type predicted;
      logic       made;
      while (!steady && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_doc_byte <= c;
      req_end_of_document <= eod;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      made = index_byte(c, eod, predicted);
      if (typed) begin
         awaited_results.insert(awaited_results.size(), typed_res);
         results_due++;
      end else if (made) begin
         awaited_results.insert(awaited_results.size(), predicted);
         results_due++;
      end
   endtask

   task automatic send_text();
      for (int i = 0; i < doc_text.size(); i++)
         push_byte(doc_text[i], i == doc_text.size() - 1, 1'b0, NO_RESULT);
      docs_sent++;
   endtask

   // Stops offering bytes until every owed result has arrived and the block is idle.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_KEY_LOW:    key_lo = value;
         CSR_KEY_HIGH:   key_hi = value;
         CSR_KEY_LENGTH: key_len = value[4:0];
         default: ;
      endcase
   endtask

   function automatic logic [7:0] key_char();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   // Chooses the key of one setting and writes all three registers.
   task automatic pick_key(input int setting);
      logic [63:0] low;
      logic [63:0] high;
      for (int i = 0; i < 16; i++) key_text[i] = key_char();
      case (setting)
         0: begin
            foreach (key_text[i]) key_text[i] = 8'hFF;
            key_span = 16;
         end
         1: key_span = 3;
         2: begin
            foreach (key_text[i]) key_text[i] = 8'h00;
            key_span = 0;
         end
         3: begin
            // An escaped quote inside the key is compared raw.
            key_text[2] = CH_BACKSLASH;
            key_text[3] = CH_QUOTE;
            key_span = 7;
         end
         4: key_span = 31;
         5: key_span = 17;
         default: key_span = $urandom_range(1, 16);
      endcase
      for (int i = 0; i < 8; i++) begin
         low[i*8 +: 8] = key_text[i];
         high[i*8 +: 8] = key_text[i+8];
      end
      write_reg(CSR_KEY_LOW, low);
      write_reg(CSR_KEY_HIGH, high);
      write_reg(CSR_KEY_LENGTH, 64'(key_span));
      csr_write <= 1'b0;
      @(posedge clock);
      key_settings++;
   endtask

   task automatic add_blank();
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 3))
            0: add_byte(CH_SPACE);
            1: add_byte(CH_TAB);
            2: add_byte(CH_LF);
            default: add_byte(CH_CR);
         endcase
      end
   endtask

   // A string with escapes, structural characters and high bytes in it.
   task automatic add_string();
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 5)) begin
         case ($urandom_range(0, 9))
            0: begin
               add_byte(CH_BACKSLASH);
               add_byte(8'($urandom_range(0, 255)));
            end
            1: begin
               case ($urandom_range(0, 4))
                  0: add_byte(CH_LBRACK);
                  1: add_byte(CH_RBRACK);
                  2: add_byte(CH_RBRACE);
                  3: add_byte(CH_COMMA);
                  default: add_byte(CH_LBRACE);
               endcase
            end
            2: add_byte(8'($urandom_range(128, 255)));
            default: add_byte(8'h61 + 8'($urandom_range(0, 25)));
         endcase
      end
      add_byte(CH_QUOTE);
   endtask

   task automatic add_value(input int level);
      string word;
      int    count;
      case ($urandom_range(0, level > 2 ? 2 : 4))
         0: begin
            if ($urandom_range(0, 3) == 0) add_byte(8'h2D);
            repeat ($urandom_range(1, 3)) add_byte(8'h30 + 8'($urandom_range(0, 9)));
         end
         1: add_string();
         2: begin
            word = ($urandom_range(0, 1) == 0) ? "true" : "null";
            foreach (word[i]) add_byte(word[i]);
         end
         3: begin
            add_byte(CH_LBRACK);
            count = $urandom_range(0, 3);
            for (int i = 0; i < count; i++) begin
               if (i != 0) add_byte(CH_COMMA);
               add_blank();
               add_value(level + 1);
               add_blank();
            end
            add_byte(CH_RBRACK);
         end
         default: begin
            add_byte(CH_LBRACE);
            count = $urandom_range(0, 2);
            for (int i = 0; i < count; i++) begin
               if (i != 0) add_byte(CH_COMMA);
               add_blank();
               add_string();
               add_blank();
               add_byte(CH_COLON);
               add_blank();
               add_value(level + 1);
            end
            add_byte(CH_RBRACE);
         end
      endcase
   endtask

   task automatic add_wanted_key();
      add_byte(CH_QUOTE);
      for (int i = 0; i < key_span; i++) add_byte(i < 16 ? key_text[i] : 8'h7A);
      add_byte(CH_QUOTE);
   endtask

   // A member whose key is random or a near miss of the wanted key.
   task automatic add_other_member();
      if ($urandom_range(0, 2) == 0) begin
         add_wanted_key();
         void'(doc_text.pop_back());
         add_byte(8'h71);
         add_byte(CH_QUOTE);
      end else begin
         add_byte(CH_QUOTE);
         repeat ($urandom_range(0, 17)) add_byte(8'h61 + 8'($urandom_range(0, 25)));
         add_byte(CH_QUOTE);
      end
      add_blank();
      add_byte(CH_COLON);
      add_blank();
      add_value(0);
   endtask

   // Array of the wanted key, with empty elements and trailing commas now and then.
   task automatic add_target_array();
      int count;
      add_byte(CH_LBRACK);
      count = $urandom_range(0, 6);
      for (int i = 0; i < count; i++) begin
         if (i != 0) add_byte(CH_COMMA);
         add_blank();
         if ($urandom_range(0, 9) != 0) begin
            add_value(0);
            add_blank();
         end
      end
      if ($urandom_range(0, 6) == 0) add_byte(CH_COMMA);
      add_blank();
      add_byte(CH_RBRACK);
   endtask

   // Mostly well-formed documents; some are cut short, damaged or plain noise.
   task automatic build_document();
      int pick;
      int cut;
      doc_text.delete();
      add_blank();
      add_byte(CH_LBRACE);
      add_blank();
      repeat ($urandom_range(0, 2)) begin
         add_other_member();
         add_byte(CH_COMMA);
         add_blank();
      end
      if ($urandom_range(0, 99) < 85) begin
         add_wanted_key();
         add_blank();
         add_byte(CH_COLON);
         add_blank();
         if ($urandom_range(0, 19) == 0) add_value(0);
         else add_target_array();
      end else begin
         add_other_member();
      end
      add_blank();
      if ($urandom_range(0, 3) == 0) begin
         add_byte(CH_COMMA);
         add_other_member();
      end
      add_byte(CH_RBRACE);
      add_blank();

      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         cut = $urandom_range(1, doc_text.size());
         doc_text = doc_text[0:cut-1];
      end else if (pick < 20) begin
         doc_text[$urandom_range(0, doc_text.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 24) begin
         doc_text.delete();
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Head of a document that opens the wanted array straight away.
   task automatic start_wanted_array();
      doc_text.delete();
      add_byte(CH_LBRACE);
      add_wanted_key();
      add_byte(CH_COLON);
      add_byte(CH_LBRACK);
   endtask

   // Receiver: random stalls, one long hold-off on request, and steady stretches.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_wanted && !hold_served) begin
            hold_served = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(0, 99) < 6);
         end
      end
   end

   // Each result transfer is checked against the oldest owed result.
   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch_results
      result_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (rsp_result_kind == KIND_SPAN) spans_seen++;
         if (awaited_results.size() == 0) begin
            $display("%0t ns: result of kind %0d arrived with none owed", $time,
                     rsp_result_kind);
            fail_count++;
         end else begin
            due = awaited_results.pop_front();
            check_field("result_kind", 32'(due.kind), 32'(rsp_result_kind));
            check_field("element_number", due.number, rsp_element_number);
            check_field("element_offset", due.offset, rsp_element_offset);
            check_field("element_length", due.length, rsp_element_length);
            check_field("final_element", 32'(due.last_flag), 32'(rsp_final_element));
            check_field("error_code", 32'(due.error_code), 32'(rsp_error_code));
         end
      end
   end

   // Stimulus.
   initial begin
      int setting;
      key_lo = '0;
      key_hi = '0;
      key_len = '0;
      clear_doc();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(OPENING_STEPS); i++)
         push_byte(OPENING_STEPS[i].ch, OPENING_STEPS[i].eod, OPENING_STEPS[i].typed,
                   OPENING_STEPS[i].want);

      // The first three key settings always run, so the pressure and the steady
      // stretch are always covered.
      setting = 0;
      while (setting < 3 || bytes_sent < ITEM_GOAL) begin
         quiesce();
         pick_key(setting);
         steady = (setting == 2);
         if (setting == 1) begin
            // Nesting past the counter limit; a wrapping counter would close the
            // array on the first closing bracket, a saturating one leaves it open.
            start_wanted_array();
            repeat (DEEP_LEVELS) add_byte(CH_LBRACK);
            repeat (2) add_byte(CH_RBRACK);
            add_byte(CH_RBRACE);
            send_text();

            // Many short elements while the receiver holds off, filling the block.
            start_wanted_array();
            for (int i = 0; i < 16; i++) begin
               if (i != 0) add_byte(CH_COMMA);
               add_byte(8'h30 + 8'(i % 10));
            end
            add_byte(CH_RBRACK);
            add_byte(CH_RBRACE);
            hold_wanted = 1'b1;
            send_text();
         end
         repeat (steady ? 3 : 2) begin
            build_document();
            send_text();
         end
         setting++;
      end

      // Let every owed result arrive, then let the block run on before the summary.
      req_valid <= 1'b0;
      steady = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d document bytes in %0d documents under %0d key settings.",
               bytes_sent, docs_sent, key_settings + 1);
      $display("Checked %0d results, %0d of them element spans.", results_seen, spans_seen);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #1_000_000;
      $display("Timed out with %0d results still owed.", awaited_results.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
src/jaei_pkg.sv
src/jaei_parser.sv
src/jaei_outbuf.sv
src/json_keyed_array_element_indexer.sv
test/json_keyed_array_element_indexer_tb.sv
